// ===== design/assert_macros.svh =====
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: lbl");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== design/amfp_pkg.sv =====
package amfp_pkg;

  localparam int VALUE_BITS = 32;

  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_W    = 8'h57;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [3:0] FIELD_NONE = 4'd0;
  localparam logic [3:0] FIELD_MAX  = 4'd8;

  typedef struct packed {
    logic                  in_frame;
    logic [1:0]            header;
    logic [3:0]            open_field;
    logic [VALUE_BITS-1:0] acc;
    logic [7:0]            hb0;
    logic [7:0]            hb1;
    logic [1:0]            hb_cnt;
    logic                  cr_pend;
  } state_t;

  typedef struct packed {
    logic [3:0]  field_number;
    logic [31:0] field_value;
    logic [1:0]  header_kind;
    logic        last_field;
  } result_t;

endpackage

// ===== design/amfp_parse.sv =====
module amfp_parse (
  input  amfp_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  input  logic              mode_i,
  output amfp_pkg::state_t  state_o,
  output logic              res_valid_o,
  output amfp_pkg::result_t res_o
);

  typedef logic [amfp_pkg::VALUE_BITS-1:0] acc_t;

  function automatic acc_t add_digit(acc_t acc, logic [7:0] b);
    acc_t t;
    t = (acc << 3) + (acc << 1) + acc_t'(b) - acc_t'(amfp_pkg::CH_ZERO);
    return t;
  endfunction

  function automatic amfp_pkg::state_t clear_field(amfp_pkg::state_t s);
    amfp_pkg::state_t r;
    r        = s;
    r.acc    = '0;
    r.hb0    = '0;
    r.hb1    = '0;
    r.hb_cnt = '0;
    return r;
  endfunction

  function automatic amfp_pkg::state_t field_byte(amfp_pkg::state_t s, logic mode,
                                                  logic [7:0] b);
    amfp_pkg::state_t r;
    logic             trimmed;
    r       = s;
    trimmed = mode && (s.open_field == 4'd2 || s.open_field == 4'd4 ||
                       s.open_field == 4'd6);
    if (s.open_field != amfp_pkg::FIELD_NONE) begin
      if (!trimmed) begin
        r.acc = add_digit(s.acc, b);
      end else if (s.hb_cnt >= 2'd2) begin
        r.acc = add_digit(s.acc, s.hb0);
        r.hb0 = s.hb1;
        r.hb1 = b;
      end else begin
        if (s.hb_cnt[0]) r.hb1 = b;
        else r.hb0 = b;
        r.hb_cnt = s.hb_cnt + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic amfp_pkg::result_t make_result(amfp_pkg::state_t s, logic last);
    amfp_pkg::result_t r;
    r.field_number = s.open_field;
    r.field_value  = 32'(s.acc);
    r.header_kind  = s.header;
    r.last_field   = last;
    return r;
  endfunction

  amfp_pkg::state_t s;
  logic             lf_done;
  logic [3:0]       k;

  always_comb begin
    s           = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    lf_done     = 1'b0;
    k           = 4'(byte_i - amfp_pkg::CH_A) + 4'd1;
    if (!s.in_frame) begin
      if (byte_i == amfp_pkg::CH_U || byte_i == amfp_pkg::CH_V ||
          byte_i == amfp_pkg::CH_W) begin
        s.in_frame   = 1'b1;
        s.header     = 2'(byte_i - amfp_pkg::CH_U);
        s.open_field = amfp_pkg::FIELD_NONE;
        s            = clear_field(s);
        s.cr_pend    = 1'b0;
      end
    end else begin
      if (s.cr_pend) begin
        s.cr_pend = 1'b0;
        if (byte_i == amfp_pkg::CH_LF) begin
          lf_done = 1'b1;
          if (s.open_field != amfp_pkg::FIELD_NONE &&
              (mode_i || s.open_field == 4'd2)) begin
            res_valid_o  = 1'b1;
            res_o        = make_result(s, 1'b1);
            s.in_frame   = 1'b0;
            s.open_field = amfp_pkg::FIELD_NONE;
            s            = clear_field(s);
          end
        end else begin
          s = field_byte(s, mode_i, amfp_pkg::CH_CR);
        end
      end
      if (!lf_done) begin
        priority if (byte_i == amfp_pkg::CH_CR) begin
          s.cr_pend = 1'b1;
        end else if (mode_i && byte_i >= amfp_pkg::CH_A && byte_i <= amfp_pkg::CH_H) begin
          if (k == s.open_field + 4'd1) begin
            if (s.open_field != amfp_pkg::FIELD_NONE) begin
              res_valid_o = 1'b1;
              res_o       = make_result(s, 1'b0);
            end
            s.open_field = k;
            s            = clear_field(s);
          end
        end else if (!mode_i && byte_i == amfp_pkg::CH_A) begin
          if (s.open_field == amfp_pkg::FIELD_NONE) begin
            s.open_field = 4'd1;
            s            = clear_field(s);
          end
        end else if (!mode_i && byte_i == amfp_pkg::CH_B) begin
          if (s.open_field == 4'd1) begin
            res_valid_o  = 1'b1;
            res_o        = make_result(s, 1'b0);
            s.open_field = 4'd2;
            s            = clear_field(s);
          end
        end else begin
          s = field_byte(s, mode_i, byte_i);
        end
      end
    end
    state_o = s;
  end

endmodule

// ===== design/amfp_out_buf.sv =====
`include "assert_macros.svh"

module amfp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  amfp_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output amfp_pkg::result_t out_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  amfp_pkg::result_t out_q, skid_q;
  logic              take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      skid_valid_d = !take;
    end else begin
      out_valid_d  = push_i || (out_valid_q && !take);
      skid_valid_d = push_i && out_valid_q && !take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q && take) begin
      out_q <= skid_q;
    end else if (push_i && (!out_valid_q || take)) begin
      out_q <= res_i;
    end
    if (push_i && out_valid_q && !take) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_PROP(a_skid_behind_out, clk_i, !rst_ni, skid_valid_q |-> out_valid_q)
  `ASSERT_NEVER(a_no_push_when_full, clk_i, !rst_ni, push_i && skid_valid_q)

endmodule

// ===== design/ascii_motor_frame_parser_top.sv =====
// ASCII motor frame parser.
// Input channel: in_valid_i / in_stall_o carry one received byte (rx_byte_i)
// per item. Output channel: out_valid_o / out_stall_i carry one closed field
// per item (field number, value, header kind, last-field flag).
// cfg_we_i / cfg_wdata_i write multi_motor_mode (0 two fields, 1 eight fields);
// write only while the block is idle.
// Throughput: one byte per cycle while in_stall_o is low. The byte lands in
// an input register, and the parse step (accumulate by ten plus digit, marker
// decode) is combinational into the result register, so a result shows on
// out_valid_o from the result register. Bytes that close no field give no item.
// A skid register behind the result register absorbs one result while the
// receiver stalls; in_stall_o rises only once that skid register is full and
// the input register still holds a byte.
// Reset: no frame open, accumulator and holdback cleared, single mode,
// both channels empty.
`include "assert_macros.svh"

module ascii_motor_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  field_number_o,
  output logic [31:0] field_value_o,
  output logic [1:0]  header_kind_o,
  output logic        last_field_o
);

  logic              mode_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  amfp_pkg::state_t  st_q, st_d;
  logic              res_valid;
  amfp_pkg::result_t res;
  amfp_pkg::result_t out_res;
  logic              buf_full;
  logic              fire;
  logic              in_accept;

  assign fire       = in_valid_q && !buf_full;
  assign in_stall_o = in_valid_q && buf_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      in_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (in_accept) in_valid_q <= 1'b1;
      else if (fire) in_valid_q <= 1'b0;
      if (fire) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_byte_q <= rx_byte_i;
  end

  amfp_parse u_parse (
    .state_i     (st_q),
    .byte_i      (in_byte_q),
    .mode_i      (mode_q),
    .state_o     (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  amfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign field_number_o = out_res.field_number;
  assign field_value_o  = out_res.field_value;
  assign header_kind_o  = out_res.header_kind;
  assign last_field_o   = out_res.last_field;

  `ASSERT_PROP(a_field_needs_frame, clk_i, !rst_ni,
               st_q.open_field != amfp_pkg::FIELD_NONE |-> st_q.in_frame)
  `ASSERT_NEVER(a_holdback_count, clk_i, !rst_ni, st_q.hb_cnt == 2'd3)
  `ASSERT_PROP(a_field_number_range, clk_i, !rst_ni,
               out_valid_o |-> (field_number_o != amfp_pkg::FIELD_NONE &&
                                field_number_o <= amfp_pkg::FIELD_MAX))

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mirrors the parser: frame/field state, accumulator and the two-byte trim delay line.
  class field_scoreboard;
    bit                multi;
    bit                in_frame;
    logic [1:0]        header;
    logic [3:0]        open_field;
    logic [31:0]       acc;
    logic [7:0]        hold [2];
    int unsigned       hold_cnt;
    bit                cr_pend;
    amfp_pkg::result_t pending_fields [$];
    int unsigned       fields_checked;

    function new();
      multi = 1'b0;
      in_frame = 1'b0;
      header = '0;
      open_field = amfp_pkg::FIELD_NONE;
      cr_pend = 1'b0;
      fields_checked = 0;
      clear_field();
    endfunction

    function void clear_field();
      acc = '0;
      hold[0] = '0;
      hold[1] = '0;
      hold_cnt = 0;
    endfunction

    function void add_digit(logic [7:0] c);
      acc = acc * 32'd10 + 32'(c) - 32'(amfp_pkg::CH_ZERO);
    endfunction

    function void push_field(bit last);
      amfp_pkg::result_t r;
      r.field_number = open_field;
      r.field_value  = acc;
      r.header_kind  = header;
      r.last_field   = last;
      pending_fields.push_back(r);
    endfunction

    function void field_byte(logic [7:0] c);
      if (open_field == amfp_pkg::FIELD_NONE) return;
      if (!(multi && (open_field == 4'd2 || open_field == 4'd4 || open_field == 4'd6))) begin
        add_digit(c);
        return;
      end
      // trimmed field: last two bytes never reach the accumulator
      if (hold_cnt >= 2) begin
        add_digit(hold[0]);
        hold[0] = hold[1];
        hold[1] = c;
      end else begin
        hold[hold_cnt] = c;
        hold_cnt++;
      end
    endfunction

    function void frame_byte(logic [7:0] b);
      logic [3:0] k;
      if (multi) begin
        if (b >= amfp_pkg::CH_A && b <= amfp_pkg::CH_H) begin
          k = 4'(b - amfp_pkg::CH_A + 8'd1);
          if (k != open_field + 4'd1) return;
          if (open_field != amfp_pkg::FIELD_NONE) push_field(1'b0);
          open_field = k;
          clear_field();
          return;
        end
      end else if (b == amfp_pkg::CH_A) begin
        if (open_field == amfp_pkg::FIELD_NONE) begin
          open_field = 4'd1;
          clear_field();
        end
        return;
      end else if (b == amfp_pkg::CH_B) begin
        if (open_field == 4'd1) begin
          push_field(1'b0);
          open_field = 4'd2;
          clear_field();
        end
        return;
      end
      field_byte(b);
    endfunction

    function void note_byte(logic [7:0] b);
      if (!in_frame) begin
        if (b == amfp_pkg::CH_U || b == amfp_pkg::CH_V || b == amfp_pkg::CH_W) begin
          in_frame = 1'b1;
          header = 2'(b - amfp_pkg::CH_U);
          open_field = amfp_pkg::FIELD_NONE;
          clear_field();
          cr_pend = 1'b0;
        end
        return;
      end
      if (cr_pend) begin
        cr_pend = 1'b0;
        if (b == amfp_pkg::CH_LF) begin
          if (open_field != amfp_pkg::FIELD_NONE && (multi || open_field == 4'd2)) begin
            push_field(1'b1);
            in_frame = 1'b0;
            open_field = amfp_pkg::FIELD_NONE;
            clear_field();
          end
          return;
        end
        field_byte(amfp_pkg::CH_CR);
      end
      if (b == amfp_pkg::CH_CR) begin
        cr_pend = 1'b1;
        return;
      end
      frame_byte(b);
    endfunction

    function bit check_field(amfp_pkg::result_t got, output string why);
      amfp_pkg::result_t want;
      why = "";
      if (pending_fields.size() == 0) begin
        why = $sformatf("field %0d value %0d arrived with none expected",
                        got.field_number, got.field_value);
        return 1'b0;
      end
      want = pending_fields.pop_front();
      fields_checked++;
      if (got.field_number !== want.field_number)
        why = {why, $sformatf(" number %0d want %0d", got.field_number, want.field_number)};
      if (got.field_value !== want.field_value)
        why = {why, $sformatf(" value %0d want %0d", got.field_value, want.field_value)};
      if (got.header_kind !== want.header_kind)
        why = {why, $sformatf(" header %0d want %0d", got.header_kind, want.header_kind)};
      if (got.last_field !== want.last_field)
        why = {why, $sformatf(" last %0b want %0b", got.last_field, want.last_field)};
      if (why != "") why = {$sformatf("field #%0d:", fields_checked), why};
      return why == "";
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  field_number_o;
  logic [31:0] field_value_o;
  logic [1:0]  header_kind_o;
  logic        last_field_o;

  field_scoreboard sb = new();
  int unsigned     errors;
  int unsigned     bytes_sent;
  bit              calm;
  bit              mode;
  string           why;

  ascii_motor_frame_parser_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_number_o (field_number_o),
    .field_value_o  (field_value_o),
    .header_kind_o  (header_kind_o),
    .last_field_o   (last_field_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = !calm && ($urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (!sb.check_field({field_number_o, field_value_o, header_kind_o, last_field_o}, why))
        report(why);
    end
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending_fields.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_mode(bit m);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = m;
    @(posedge clk_i);
    sb.multi = m;
    mode     = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [7:0] field_char();
    if ($urandom_range(0, 99) < 82) return amfp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame();
    int nf;
    int f;
    int len;
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    send_byte(amfp_pkg::CH_U + 8'($urandom_range(0, 2)));
    nf = mode ? $urandom_range(1, amfp_pkg::FIELD_MAX) : 2;
    for (f = 1; f <= nf; f++) begin
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 24) != 0) send_byte(amfp_pkg::CH_A + 8'(f - 1));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 5);
      repeat (len) send_byte(field_char());
    end
    // a few frames are left unterminated so the next header lands inside a field
    if ($urandom_range(0, 19) != 0) begin
      send_byte(amfp_pkg::CH_CR);
      send_byte(amfp_pkg::CH_LF);
    end
  endtask

  task automatic run_frames(int unsigned n);
    int unsigned stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      send_frame();
      if ($urandom_range(0, 14) == 0) wait_idle();
    end
  endtask

  initial begin
    int spin;
    errors      = 0;
    bytes_sent  = 0;
    calm        = 1'b0;
    mode        = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b0);
    // junk before header, misplaced CR LF, CR LF with field 1 open, held CR as a field byte
    send_byte(8'h00);
    send_byte(8'hff);
    send_text("V\015\nA9");
    send_byte(8'hff);
    send_text("\015\nCB\0157A\015\n");

    write_mode(1'b1);
    // out-of-order markers, short and trimmed field 2
    send_text("UBA1C2B34567C8\015\n");

    write_mode(1'b0);
    run_frames(220);
    write_mode(1'b1);
    run_frames(220);
    calm = 1'b1;
    run_frames(200);
    calm = 1'b0;
    write_mode(1'b0);
    run_frames(210);

    in_valid_i = 1'b0;
    for (spin = 0; spin < 5000 && sb.pending_fields.size() != 0; spin++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.pending_fields.size() != 0)
      report($sformatf("%0d fields never arrived", sb.pending_fields.size()));

    $display("Sent %0d bytes of frames and noise; checked %0d closed fields", bytes_sent,
             sb.fields_checked);
    $display("in single and multi mode, with random gaps, stalls and a gap-free stretch.");
    if (errors == 0) begin
      $display("** ascii_motor_frame_parser_top: PASSED **");
    end else begin
      $display("** ascii_motor_frame_parser_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("** ascii_motor_frame_parser_top: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/amfp_pkg.sv
design/amfp_parse.sv
design/amfp_out_buf.sv
design/ascii_motor_frame_parser_top.sv
dv/tb.sv
